[sv/dss_pkg.sv]
`timescale 1ns / 1ps
// dss_pkg: types and constants for the decoder stream selector
// depends on nothing; used by decoder_stream_selector_top

package dss_pkg;

   // table size and derived index widths
   localparam int MAX_STREAMS = 8;
   localparam int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
   localparam int PTS_W       = 48;
   localparam int STAMP_W     = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   // command codes
   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_UPDATE = 1'b1
   } cmd_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STREAMS_IN_USE = 1'b0,
      CSR_NEAR_DISTANCE  = 1'b1
   } csr_index_type;

   // tier that produced the choice
   typedef enum logic [1:0] {
      MK_EXACT  = 2'd0,
      MK_NEARBY = 2'd1,
      MK_GROUP  = 2'd2,
      MK_LRU    = 2'd3
   } match_kind_type;

   // input word
   typedef struct packed {
      cmd_type                  cmd;
      logic signed [PTS_W-1:0]  wanted_pts;
      logic signed [PTS_W-1:0]  group_key_pts;
      logic                     group_key_known;
      logic [2:0]               entry_sel;
      logic signed [PTS_W-1:0]  entry_pts;
      logic signed [PTS_W-1:0]  entry_key_pts;
      logic                     entry_key_known;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [2:0]     chosen_stream;
      logic           seek_needed;
      match_kind_type match_kind;
   } rsp_word_type;

   // one context entry as held in the context memory
   typedef struct packed {
      logic signed [PTS_W-1:0] cur_pts;
      logic signed [PTS_W-1:0] key_pts;
      logic                    key_valid;
   } ctx_entry_type;

endpackage

[sv/decoder_stream_selector_top.sv]
`timescale 1ns / 1ps
// decoder_stream_selector_top: context table and four-tier context search
// depends on dss_pkg
//
// Usage:
//  - input words arrive on req_word, taken at a clock edge with start high and
//    busy low. An update word rewrites one context and gives no result; a
//    lookup word gives exactly one result word.
//  - the result is on rsp_word, marked by rsp_strobe for one cycle; the
//    receiver cannot stall it, so it must take it in that cycle.
//  - an update leaves busy low, so another word may follow.
//  - a lookup scans the open contexts one memory read per cycle, through the
//    single read port of the context and use-stamp memories. busy stays high
//    through the scan and the choice, and rsp_strobe rises in the cycle busy falls.
//  - csr_we writes streams_in_use (index 0) or near_distance (index 1); write
//    only while busy is low.
//  - reset clears control state, the use clock and the per-entry valid bits;
//    an entry never written reads as all zero. No clearing pass is needed.

module decoder_stream_selector_top
   import dss_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_word_type           req_word,
   output logic                   rsp_strobe,
   output rsp_word_type           rsp_word,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control state
   state_type              state_ff;
   logic [CNT_W-1:0]       rd_cnt_ff;
   logic                   eval_ff;
   logic [IDX_W-1:0]       eval_idx_ff;
   logic                   rsp_strobe_ff;
   rsp_word_type           rsp_word_ff;
   logic [STAMP_W-1:0]     use_clock_ff;

   // configuration
   logic [3:0]             streams_ff;
   logic [31:0]            near_dist_cfg_ff;

   // lookup operands
   logic signed [PTS_W-1:0] target_ff;
   logic signed [PTS_W-1:0] gkey_ff;
   logic                    gknown_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [CNT_W-1:0]        n_in;

   // memories and valid bits
   ctx_entry_type          ctx_mem [MAX_STREAMS];
   logic [STAMP_W-1:0]     use_mem [MAX_STREAMS];
   logic [MAX_STREAMS-1:0] ctx_vld_ff;
   logic [MAX_STREAMS-1:0] use_vld_ff;
   ctx_entry_type          ctx_rd_ff;
   logic [STAMP_W-1:0]     use_rd_ff;
   logic                   ctx_rd_vld_ff;
   logic                   use_rd_vld_ff;

   logic                   accept;
   logic                   ctx_we;
   logic [IDX_W-1:0]       ctx_waddr;
   ctx_entry_type          ctx_wdata;
   logic                   use_we;
   logic [IDX_W-1:0]       rd_addr;

   // scan evaluation
   ctx_entry_type           ent;
   logic [STAMP_W-1:0]      stamp;
   logic signed [PTS_W:0]   diff;
   logic                    diff_pos;
   logic                    not_past;
   logic                    key_match;

   // accumulators
   logic                    exact_hit_ff;
   logic [IDX_W-1:0]        exact_idx_ff;
   logic                    near_hit_ff;
   logic [IDX_W-1:0]        near_idx_ff;
   logic signed [PTS_W:0]   near_gap_ff;
   logic                    grp_hit_ff;
   logic [IDX_W-1:0]        grp_idx_ff;
   logic signed [PTS_W:0]   grp_gap_ff;
   logic [IDX_W-1:0]        lru_idx_ff;
   logic [STAMP_W-1:0]      lru_stamp_ff;

   // final choice
   logic [IDX_W-1:0]        chosen;
   match_kind_type          kind;
   logic                    near_ok;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // clamp the open count to 1..MAX_STREAMS
   always_comb begin
      if (streams_ff == 4'd0) begin
         n_in = CNT_W'(1);
      end else if (32'(streams_ff) > 32'(MAX_STREAMS)) begin
         n_in = CNT_W'(MAX_STREAMS);
      end else begin
         n_in = CNT_W'(streams_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         streams_ff       <= 4'd1;
         near_dist_cfg_ff <= 32'd45000;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_STREAMS_IN_USE: streams_ff       <= csr_wdata[3:0];
            CSR_NEAR_DISTANCE:  near_dist_cfg_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // update writes go straight into the context memory
   assign ctx_we    = accept && (req_word.cmd == CMD_UPDATE) &&
                      (32'(req_word.entry_sel) < 32'(MAX_STREAMS));
   assign ctx_waddr = IDX_W'(req_word.entry_sel);
   assign ctx_wdata = '{cur_pts:   req_word.entry_pts,
                        key_pts:   req_word.entry_key_pts,
                        key_valid: req_word.entry_key_known};
   assign use_we    = (state_ff == ST_DONE);
   assign rd_addr   = rd_cnt_ff[IDX_W-1:0];

   // memories, registered read
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
      end
      if (use_we) begin
         use_mem[chosen] <= use_clock_ff + STAMP_W'(1);
      end
      ctx_rd_ff     <= ctx_mem[rd_addr];
      use_rd_ff     <= use_mem[rd_addr];
      ctx_rd_vld_ff <= ctx_vld_ff[rd_addr];
      use_rd_vld_ff <= use_vld_ff[rd_addr];
   end

   // per-entry valid bits, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_vld_ff <= '0;
         use_vld_ff <= '0;
      end else begin
         if (ctx_we) begin
            ctx_vld_ff[ctx_waddr] <= 1'b1;
         end
         if (use_we) begin
            use_vld_ff[chosen] <= 1'b1;
         end
      end
   end

   // entry under evaluation
   always_comb begin
      ent       = ctx_rd_vld_ff ? ctx_rd_ff : '0;
      stamp     = use_rd_vld_ff ? use_rd_ff : '0;
      diff      = {target_ff[PTS_W-1], target_ff} - {ent.cur_pts[PTS_W-1], ent.cur_pts};
      diff_pos  = !diff[PTS_W] && (diff != '0);
      not_past  = !diff[PTS_W];
      key_match = ent.key_valid && (ent.key_pts == gkey_ff);
   end

   // running best per tier
   always_ff @(posedge clock) begin
      if (accept) begin
         target_ff    <= req_word.wanted_pts;
         gkey_ff      <= req_word.group_key_pts;
         gknown_ff    <= req_word.group_key_known;
         n_ff         <= n_in;
         exact_hit_ff <= 1'b0;
         near_hit_ff  <= 1'b0;
         grp_hit_ff   <= 1'b0;
      end else if (eval_ff) begin
         // exact timestamp, first index wins
         if (!exact_hit_ff && (ent.cur_pts == target_ff)) begin
            exact_hit_ff <= 1'b1;
            exact_idx_ff <= eval_idx_ff;
         end
         // nearest entry with a valid key behind the target
         if (ent.key_valid && diff_pos && (!near_hit_ff || (diff < near_gap_ff))) begin
            near_hit_ff <= 1'b1;
            near_idx_ff <= eval_idx_ff;
            near_gap_ff <= diff;
         end
         // nearest same-group entry not past the target
         if (key_match && not_past && (!grp_hit_ff || (diff < grp_gap_ff))) begin
            grp_hit_ff <= 1'b1;
            grp_idx_ff <= eval_idx_ff;
            grp_gap_ff <= diff;
         end
         // least recently used
         if ((eval_idx_ff == '0) || (stamp < lru_stamp_ff)) begin
            lru_idx_ff   <= eval_idx_ff;
            lru_stamp_ff <= stamp;
         end
      end
   end

   // tier priority
   always_comb begin
      near_ok = near_hit_ff && (near_gap_ff < $signed({17'd0, near_dist_cfg_ff}));
      priority if (exact_hit_ff) begin
         chosen = exact_idx_ff;
         kind   = MK_EXACT;
      end else if (near_ok) begin
         chosen = near_idx_ff;
         kind   = MK_NEARBY;
      end else if (gknown_ff && grp_hit_ff) begin
         chosen = grp_idx_ff;
         kind   = MK_GROUP;
      end else begin
         chosen = lru_idx_ff;
         kind   = MK_LRU;
      end
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         eval_ff       <= 1'b0;
         eval_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_word_ff   <= '0;
         use_clock_ff  <= '0;
      end else begin
         // strobe in the cycle after the choice is made
         rsp_strobe_ff <= (state_ff == ST_DONE);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_word.cmd == CMD_LOOKUP)) begin
                  rd_cnt_ff <= '0;
                  eval_ff   <= 1'b0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_cnt_ff < n_ff) begin
                  rd_cnt_ff   <= rd_cnt_ff + CNT_W'(1);
                  eval_ff     <= 1'b1;
                  eval_idx_ff <= rd_addr;
               end else begin
                  eval_ff <= 1'b0;
               end
               if (eval_ff && (rd_cnt_ff == n_ff)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_word_ff.chosen_stream <= 3'(chosen);
               rsp_word_ff.seek_needed   <= (kind == MK_LRU);
               rsp_word_ff.match_kind    <= kind;
               use_clock_ff              <= use_clock_ff + STAMP_W'(1);
               state_ff                  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a result is only shown once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // seek is needed exactly for the least recently used tier
   a_seek_lru: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.seek_needed == (rsp_word.match_kind == MK_LRU)))
      else $error("seek_needed disagrees with match kind");

   // each result advances the use clock by one
   a_use_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (use_clock_ff == $past(use_clock_ff) + STAMP_W'(1)))
      else $error("use clock not advanced with result");

   // the scan counter never goes past the open count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_cnt_ff <= n_ff))
      else $error("scan counter past open count");

endmodule
